>>> rtl/core/hsd_pkg.sv
// Shared types and constants of the Huffman stream decoder.
`default_nettype none

package hsd_pkg;

  localparam int NODE_SLOTS_DEF  = 511;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int IDX_W = 9;

  localparam logic [7:0] LEAF_MARK = 8'h31;
  localparam logic [7:0] MAX_PAD   = 8'd8;

  localparam logic [1:0] ST_SYMBOL = 2'd0;
  localparam logic [1:0] ST_END    = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic       leaf;
    logic [7:0] sym;
    idx_t       left;
    idx_t       right;
  } entry_t;

  typedef struct packed {
    logic       take_in;
    logic       hsym_wr;
    logic       stk_rd;
    logic       par_wr;
    logic       new_wr;
    logic       pad_ld;
    logic       root_rd;
    logic       root_ld;
    logic       walk_step;
    logic       push;
    logic [1:0] push_status;
    logic       fin_out;
    logic       restart;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic expect_sym;
    logic count_full;
    logic count_zero;
    logic level_zero;
    logic stack_full;
    logic is_leaf_mark;
    logic pad_bad;
    logic walk_more;
    logic walk_err;
    logic can_push;
    logic can_fin;
    logic pr_valid;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/hsd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module hsd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hsd_ctrl.sv
// Control state machine of the Huffman stream decoder.
`default_nettype none

module hsd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hsd_pkg::stat_t st,
  output hsd_pkg::cmd_t       cmd
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PAD    = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HSYM  = 4'd1;
  localparam logic [3:0] S_HNODE = 4'd2;
  localparam logic [3:0] S_HPAR  = 4'd3;
  localparam logic [3:0] S_HNEW  = 4'd4;
  localparam logic [3:0] S_PAD   = 4'd5;
  localparam logic [3:0] S_ROOT  = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_WERR  = 4'd8;
  localparam logic [3:0] S_WEND  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          unique case (phase_r)
            PH_HEADER: state_nxt = st.expect_sym ? S_HSYM : S_HNODE;
            PH_PAD:    state_nxt = S_PAD;
            PH_DATA:   state_nxt = S_WALK;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_HSYM: begin
        cmd.hsym_wr = 1'b1;
        if (st.level_zero) begin
          phase_nxt = PH_PAD;
        end
        if (st.fin) begin
          cmd.push        = 1'b1;
          cmd.push_status = hsd_pkg::ST_ERROR;
        end
        state_nxt = S_FIN;
      end
      S_HNODE: begin
        if (st.count_full || (!st.count_zero && st.level_zero)) begin
          cmd.push        = 1'b1;
          cmd.push_status = hsd_pkg::ST_ERROR;
          phase_nxt       = PH_ERROR;
          state_nxt       = S_FIN;
        end else if (st.count_zero) begin
          state_nxt = S_HNEW;
        end else begin
          cmd.stk_rd = 1'b1;
          state_nxt  = S_HPAR;
        end
      end
      S_HPAR: begin
        cmd.par_wr = 1'b1;
        state_nxt  = S_HNEW;
      end
      S_HNEW: begin
        cmd.new_wr = 1'b1;
        if (!st.is_leaf_mark && st.stack_full) begin
          cmd.push        = 1'b1;
          cmd.push_status = hsd_pkg::ST_ERROR;
          phase_nxt       = PH_ERROR;
        end else if (st.fin) begin
          cmd.push        = 1'b1;
          cmd.push_status = hsd_pkg::ST_ERROR;
        end
        state_nxt = S_FIN;
      end
      S_PAD: begin
        if (st.pad_bad) begin
          cmd.push        = 1'b1;
          cmd.push_status = hsd_pkg::ST_ERROR;
          phase_nxt       = PH_ERROR;
          state_nxt       = S_FIN;
        end else begin
          cmd.pad_ld  = 1'b1;
          cmd.root_rd = 1'b1;
          phase_nxt   = PH_DATA;
          if (st.fin) begin
            cmd.push        = 1'b1;
            cmd.push_status = hsd_pkg::ST_END;
          end
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_ld = 1'b1;
        state_nxt   = S_FIN;
      end
      S_WALK: begin
        if (st.can_push) begin
          cmd.walk_step = 1'b1;
          if (!st.walk_more) begin
            state_nxt = S_WEND;
          end else if (st.walk_err) begin
            state_nxt = S_WERR;
          end
        end
      end
      S_WERR: begin
        if (st.can_push) begin
          cmd.push        = 1'b1;
          cmd.push_status = hsd_pkg::ST_ERROR;
          phase_nxt       = PH_ERROR;
          state_nxt       = S_FIN;
        end
      end
      S_WEND: begin
        if (st.fin && !st.pr_valid) begin
          cmd.push        = 1'b1;
          cmd.push_status = hsd_pkg::ST_END;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (st.can_fin) begin
          cmd.fin_out = 1'b1;
          if (st.fin) begin
            cmd.restart = 1'b1;
            phase_nxt   = PH_HEADER;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_HEADER;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Walk steps and the closing error only ever start with room for a result.
  a_walk_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> st.can_push)
    else $error("walk step without room for a result");

  // The input side is closed whenever an item is being worked on.
  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input open while busy");

  // After a restart the next item is again a header item.
  a_restart_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> (phase_r == PH_HEADER))
    else $error("restart did not return to header");

endmodule

`default_nettype wire

>>> rtl/core/hsd_dp.sv
// Datapath of the Huffman stream decoder: node table, stack, walk and result queue.
`default_nettype none

module hsd_dp #(
  parameter int NODE_SLOTS  = hsd_pkg::NODE_SLOTS_DEF,
  parameter int STACK_DEPTH = hsd_pkg::STACK_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_final_byte,
  input  wire hsd_pkg::cmd_t cmd,
  output hsd_pkg::stat_t     st,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_symbol,
  output logic [1:0]         out_status,
  output logic               out_run_end
);

  localparam int TAW = $clog2(NODE_SLOTS);
  localparam int CW  = $clog2(NODE_SLOTS + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);

  logic [7:0]    byte_r;
  logic          fin_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          expect_r, expect_nxt;
  logic [3:0]    pad_r;
  logic [3:0]    nbits_r;
  logic [3:0]    bit_r;
  logic          pend_r;
  hsd_pkg::entry_t node_e_r, root_r;

  logic          pr_valid_r;
  logic [7:0]    pr_sym_r;
  logic [1:0]    pr_status_r;
  logic          out_valid_r;

  // Node table and stack.
  logic            tbl_we, tbl_re;
  logic [TAW-1:0]  tbl_waddr, tbl_raddr;
  hsd_pkg::entry_t tbl_wdata, tbl_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  hsd_pkg::idx_t   stk_rdata;

  hsd_ram #(.W($bits(hsd_pkg::entry_t)), .DEPTH(NODE_SLOTS)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  hsd_ram #(.W(hsd_pkg::IDX_W), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(hsd_pkg::idx_t'(count_r)),
    .re(cmd.stk_rd), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  hsd_pkg::idx_t   idx_cur, idx_m1;
  logic            left_free;
  logic            is_leaf_mark;
  logic            stack_full;
  hsd_pkg::entry_t e_next;
  logic            ce_leaf;
  logic            walk_more;
  logic            bit_val;
  hsd_pkg::idx_t   child;
  logic            walk_err;
  logic            walk_issue;
  logic            out_ok;
  logic            can_push;
  logic            push_req;
  logic [7:0]      push_sym;
  logic [1:0]      push_status;

  assign idx_cur      = hsd_pkg::idx_t'(count_r);
  assign idx_m1       = idx_cur - hsd_pkg::idx_t'(1);
  assign left_free    = (stk_rdata == idx_m1);
  assign is_leaf_mark = (byte_r == hsd_pkg::LEAF_MARK);
  assign stack_full   = (level_r >= LW'(STACK_DEPTH));

  // One tree step per cycle while the result queue has room: the child read by
  // the previous step is resolved, and the next child is looked up from the resulting node.
  assign ce_leaf    = pend_r && tbl_rdata.leaf;
  assign e_next     = pend_r ? (tbl_rdata.leaf ? root_r : tbl_rdata) : node_e_r;
  assign walk_more  = (bit_r < nbits_r);
  assign bit_val    = byte_r[3'd7 - bit_r[2:0]];
  assign child      = bit_val ? e_next.right : e_next.left;
  assign walk_err   = walk_more && (e_next.leaf || (child == '0));
  assign walk_issue = cmd.walk_step && walk_more && !walk_err;

  assign out_ok   = !out_valid_r || out_ready;
  assign can_push = !pr_valid_r || out_ok;

  assign push_req    = cmd.push || (cmd.walk_step && ce_leaf);
  assign push_sym    = cmd.push ? 8'd0 : tbl_rdata.sym;
  assign push_status = cmd.push ? cmd.push_status : hsd_pkg::ST_SYMBOL;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = TAW'(count_r);
    tbl_wdata = '0;
    if (cmd.hsym_wr) begin
      tbl_we         = 1'b1;
      tbl_waddr      = TAW'(idx_m1);
      tbl_wdata.leaf = 1'b1;
      tbl_wdata.sym  = byte_r;
    end else if (cmd.par_wr) begin
      tbl_we    = 1'b1;
      tbl_waddr = TAW'(stk_rdata);
      if (left_free) begin
        tbl_wdata.left = idx_cur;
      end else begin
        tbl_wdata.left  = stk_rdata + hsd_pkg::idx_t'(1);
        tbl_wdata.right = idx_cur;
      end
    end else if (cmd.new_wr) begin
      tbl_we         = 1'b1;
      tbl_wdata.leaf = is_leaf_mark;
    end
  end

  assign tbl_re    = cmd.root_rd || walk_issue;
  assign tbl_raddr = cmd.root_rd ? '0 : TAW'(child);

  assign stk_we    = cmd.new_wr && !is_leaf_mark && !stack_full;
  assign stk_waddr = SAW'(level_r);
  assign stk_raddr = SAW'(level_r - LW'(1));

  always_comb begin
    count_nxt  = count_r;
    level_nxt  = level_r;
    expect_nxt = expect_r;
    if (cmd.hsym_wr) begin
      expect_nxt = 1'b0;
    end
    if (cmd.par_wr && !left_free) begin
      level_nxt = level_r - LW'(1);
    end
    if (cmd.new_wr) begin
      count_nxt = count_r + CW'(1);
      if (is_leaf_mark) begin
        expect_nxt = 1'b1;
      end else if (!stack_full) begin
        level_nxt = level_r + LW'(1);
      end
    end
    if (cmd.restart) begin
      count_nxt  = '0;
      level_nxt  = '0;
      expect_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      level_r     <= '0;
      expect_r    <= 1'b0;
      pad_r       <= '0;
      pend_r      <= 1'b0;
      bit_r       <= '0;
      nbits_r     <= '0;
      pr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      level_r  <= level_nxt;
      expect_r <= expect_nxt;
      if (cmd.take_in) begin
        bit_r   <= '0;
        nbits_r <= in_final_byte ? (4'd8 - pad_r) : 4'd8;
      end
      if (cmd.pad_ld) begin
        pad_r <= byte_r[3:0];
      end
      if (cmd.restart) begin
        pad_r <= '0;
      end
      if (cmd.root_ld) begin
        pend_r <= 1'b0;
      end
      if (cmd.walk_step) begin
        pend_r <= walk_issue;
        if (walk_issue) begin
          bit_r <= bit_r + 4'd1;
        end
      end
      // Result queue: the newest result waits in the holding stage until it
      // is known whether it is the last one of its item.
      if (push_req) begin
        pr_valid_r <= 1'b1;
      end else if (cmd.fin_out && pr_valid_r) begin
        pr_valid_r <= 1'b0;
      end
      if (pr_valid_r && (push_req || cmd.fin_out)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      byte_r <= in_byte;
      fin_r  <= in_final_byte;
    end
    if (cmd.root_ld) begin
      root_r   <= tbl_rdata;
      node_e_r <= tbl_rdata;
    end
    if (cmd.walk_step) begin
      node_e_r <= e_next;
    end
    if (push_req) begin
      pr_sym_r    <= push_sym;
      pr_status_r <= push_status;
      if (pr_valid_r) begin
        out_symbol  <= pr_sym_r;
        out_status  <= pr_status_r;
        out_run_end <= 1'b0;
      end
    end else if (cmd.fin_out && pr_valid_r) begin
      out_symbol  <= pr_sym_r;
      out_status  <= pr_status_r;
      out_run_end <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    st              = '0;
    st.fin          = fin_r;
    st.expect_sym   = expect_r;
    st.count_full   = (count_r >= CW'(NODE_SLOTS));
    st.count_zero   = (count_r == '0);
    st.level_zero   = (level_r == '0);
    st.stack_full   = stack_full;
    st.is_leaf_mark = is_leaf_mark;
    st.pad_bad      = (byte_r > hsd_pkg::MAX_PAD);
    st.walk_more    = walk_more;
    st.walk_err     = walk_err;
    st.can_push     = can_push;
    st.can_fin      = !pr_valid_r || out_ok;
    st.pr_valid     = pr_valid_r;
  end

  // A result is never pushed over a full holding stage.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push_req |-> can_push)
    else $error("result queue overrun");

  // Counters stay within their stores.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(NODE_SLOTS)) && (level_r <= LW'(STACK_DEPTH)))
    else $error("node count or stack level out of range");

  // Every issued child lookup is resolved on the next walk step.
  a_pend_set: assert property (@(posedge clk) disable iff (!rst_n)
    walk_issue |=> pend_r)
    else $error("child lookup lost");

  // The last result of an item leaves the holding stage only into a free slot.
  a_fin_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_out && pr_valid_r) |-> out_ok)
    else $error("final result dropped");

endmodule

`default_nettype wire

>>> rtl/core/huffman_stream_decoder.sv
// Top level of the Huffman stream decoder.
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid in_ready in_byte in_final_byte       | in
//  result  | out_valid out_ready out_symbol out_status     | out
//          | out_run_end                                   |
//
// Items are handled one at a time, each ending in S_FIN. A header item passes
// S_HSYM, or S_HNODE, S_HPAR if a parent waits, and S_HNEW; the padding-count
// item passes S_PAD and S_ROOT; a data item walks the tree one code bit per step,
// each step set by one dependent node-table read. Reset clears the controller,
// counters and result queue; node table and stack hold no reset value and are
// written before they are read. A stalled result side holds the walk and S_FIN
// on a full two-entry result queue; the next item may enter while a result waits.
`default_nettype none

module huffman_stream_decoder #(
  parameter int NODE_SLOTS  = hsd_pkg::NODE_SLOTS_DEF,
  parameter int STACK_DEPTH = hsd_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_final_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_symbol,
  output logic [1:0]      out_status,
  output logic            out_run_end
);

  // Commands flow from the controller to the datapath, status flows back.
  hsd_pkg::cmd_t  cmd;
  hsd_pkg::stat_t st;

  hsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the node table, the stack of internal nodes that still
  // lack a right child, the tree walk and the result queue.
  hsd_dp #(
    .NODE_SLOTS  (NODE_SLOTS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_symbol    (out_symbol),
    .out_status    (out_status),
    .out_run_end   (out_run_end)
  );

endmodule

`default_nettype wire
